// ===== src/fpst_pkg.sv =====
// Shared constants and controller/datapath link types for the prefix-sum table.
`timescale 1ns / 1ps
`default_nettype none

package fpst_pkg;

   // Field widths of the request and response items
   localparam int unsigned POS_W  = 16;
   localparam int unsigned DATA_W = 32;

   // Default highest position held in the table
   localparam int unsigned MAX_INDEX_DEFAULT = 65535;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture an accepted item, clear the accumulator
      logic clear;       // write zero at the walk index, step up by one
      logic upd_read;    // read the node at the walk index
      logic upd_write;   // write node + delta, step to the next covering node
      logic qry_read;    // read the node at the walk index, step to the parent prefix
      logic qry_sub;     // the read issued this cycle is subtracted
      logic load_lo;     // start the lower prefix walk
      logic out_load;    // move the accumulator into the response register
   } fpst_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_query;    // request item is a range sum
      logic upd_skip;    // request item adds at position zero or past the table
      logic qry_empty;   // request item has low above high
      logic idx_zero;    // prefix walk finished
      logic upd_last;    // next covering node lies past the table
      logic clear_last;  // clear pass is at the last entry
   } fpst_sts_type;

endpackage : fpst_pkg

`default_nettype wire

// ===== src/fpst_if.sv =====
// Request and response channel interfaces of the prefix-sum table.
`timescale 1ns / 1ps
`default_nettype none

interface fpst_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic [fpst_pkg::POS_W-1:0]          update_index;
   logic signed [fpst_pkg::DATA_W-1:0]  delta;
   logic [fpst_pkg::POS_W-1:0]          range_low;
   logic [fpst_pkg::POS_W-1:0]          range_high;

   modport source (
      output valid, action, update_index, delta, range_low, range_high,
      input  ready
   );
   modport sink (
      input  valid, action, update_index, delta, range_low, range_high,
      output ready
   );
endinterface : fpst_req_if

interface fpst_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fpst_pkg::DATA_W-1:0]  range_sum;

   modport source (
      output valid, range_sum,
      input  ready
   );
   modport sink (
      input  valid, range_sum,
      output ready
   );
endinterface : fpst_rsp_if

`default_nettype wire

// ===== src/fpst_dp.sv =====
// Datapath of the prefix-sum table: node memory, walk index, accumulator, response register.
`timescale 1ns / 1ps
`default_nettype none

module fpst_dp #(
   parameter int unsigned MAX_INDEX = fpst_pkg::MAX_INDEX_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fpst_pkg::fpst_cmd_type              cmd,
   output fpst_pkg::fpst_sts_type                   sts,
   input  wire logic                                action,
   input  wire logic [fpst_pkg::POS_W-1:0]          update_index,
   input  wire logic [fpst_pkg::DATA_W-1:0]         delta,
   input  wire logic [fpst_pkg::POS_W-1:0]          range_low,
   input  wire logic [fpst_pkg::POS_W-1:0]          range_high,
   output logic signed [fpst_pkg::DATA_W-1:0]       range_sum
);

   localparam int unsigned IW = $clog2(MAX_INDEX + 1);
   localparam int unsigned CW = ((IW > fpst_pkg::POS_W) ? IW : fpst_pkg::POS_W) + 1;
   localparam logic [CW-1:0] MaxC = CW'(MAX_INDEX);
   localparam logic [IW:0]   MaxW = (IW + 1)'(MAX_INDEX);

   // Node memory, single port
   logic [fpst_pkg::DATA_W-1:0] mem_q [0:MAX_INDEX];

   logic [IW:0]                   idx_ff, idx_in;
   logic [IW:0]                   lo_ff;
   logic [fpst_pkg::DATA_W-1:0]   delta_ff;
   logic [fpst_pkg::DATA_W-1:0]   rdata_ff;
   logic [fpst_pkg::DATA_W-1:0]   acc_ff, acc_in;
   logic signed [fpst_pkg::DATA_W-1:0] sum_ff;
   logic                          pend_ff, sub_ff;

   logic [CW-1:0] upd_c, lo_c, hi_c, lo1_c, lo_prev_c, hi_pos_c, lo_pos_c;
   logic [IW:0]   low_bit, up_next, dn_next;
   logic [IW-1:0] addr;
   logic [fpst_pkg::DATA_W-1:0] wdata;
   logic          wr_en, rd_en;

   // Decode the request item
   always_comb begin
      upd_c     = CW'(update_index);
      lo_c      = CW'(range_low);
      hi_c      = CW'(range_high);
      lo1_c     = (lo_c == '0) ? CW'(1) : lo_c;
      lo_prev_c = lo1_c - CW'(1);
      hi_pos_c  = (hi_c > MaxC) ? MaxC : hi_c;
      lo_pos_c  = (lo_prev_c > MaxC) ? MaxC : lo_prev_c;
   end

   // Walk arithmetic: lowest set bit, next covering node, parent prefix
   always_comb begin
      low_bit = idx_ff & (~idx_ff + {{IW{1'b0}}, 1'b1});
      up_next = idx_ff + low_bit;
      dn_next = idx_ff - low_bit;
   end

   always_comb begin
      sts.is_query   = action;
      sts.upd_skip   = (upd_c == '0) || (upd_c > MaxC);
      sts.qry_empty  = lo1_c > hi_c;
      sts.idx_zero   = (idx_ff == '0);
      sts.upd_last   = up_next > MaxW;
      sts.clear_last = (idx_ff[IW-1:0] == IW'(MAX_INDEX));
   end

   // Advance the walk index
   always_comb begin
      idx_in = idx_ff;
      priority if (cmd.load) begin
         idx_in = action ? hi_pos_c[IW:0] : upd_c[IW:0];
      end else if (cmd.load_lo) begin
         idx_in = lo_ff;
      end else if (cmd.clear) begin
         idx_in = idx_ff + {{IW{1'b0}}, 1'b1};
      end else if (cmd.upd_write) begin
         idx_in = up_next;
      end else if (cmd.qry_read) begin
         idx_in = dn_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         pend_ff <= cmd.qry_read;
      end
   end

   // Capture the item payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         delta_ff <= delta;
         lo_ff    <= lo_pos_c[IW:0];
      end
      sub_ff <= cmd.qry_sub;
   end

   // Node memory port
   assign addr  = idx_ff[IW-1:0];
   assign wr_en = cmd.clear | cmd.upd_write;
   assign rd_en = cmd.upd_read | cmd.qry_read;
   assign wdata = cmd.clear ? '0 : rdata_ff + delta_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_q[addr];
      end
   end

   // Accumulate returned nodes: upper prefix adds, lower prefix subtracts
   always_comb begin
      acc_in = acc_ff;
      priority if (cmd.load) begin
         acc_in = '0;
      end else if (pend_ff) begin
         acc_in = sub_ff ? acc_ff - rdata_ff : acc_ff + rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.out_load) begin
         sum_ff <= acc_ff;
      end
   end

   assign range_sum = sum_ff;

endmodule : fpst_dp

`default_nettype wire

// ===== src/fpst_ctrl.sv =====
// Controller of the prefix-sum table: clear pass, update and query sequencing, response valid.
`timescale 1ns / 1ps
`default_nettype none

module fpst_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output fpst_pkg::fpst_cmd_type      cmd,
   input  wire fpst_pkg::fpst_sts_type sts
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_UPD_RD = 3'd2;
   localparam logic [2:0] S_UPD_WR = 3'd3;
   localparam logic [2:0] S_QHI    = 3'd4;
   localparam logic [2:0] S_QLO    = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Sequence the datapath
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.is_query) begin
                  state_in = sts.qry_empty ? S_DONE : S_QHI;
               end else if (!sts.upd_skip) begin
                  state_in = S_UPD_RD;
               end
            end
         end
         S_UPD_RD: begin
            cmd.upd_read = 1'b1;
            state_in     = S_UPD_WR;
         end
         S_UPD_WR: begin
            cmd.upd_write = 1'b1;
            state_in      = sts.upd_last ? S_IDLE : S_UPD_RD;
         end
         S_QHI: begin
            if (!sts.idx_zero) begin
               cmd.qry_read = 1'b1;
            end else begin
               cmd.load_lo = 1'b1;
               state_in    = S_QLO;
            end
         end
         S_QLO: begin
            if (!sts.idx_zero) begin
               cmd.qry_read = 1'b1;
               cmd.qry_sub  = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the response until taken
   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : fpst_ctrl

`default_nettype wire

// ===== src/fenwick_prefix_sum_table_core.sv =====
// Top level of the binary indexed prefix-sum table.
//
// Binary indexed tree of 32-bit wrapping sums over positions 1..MAX_INDEX, kept in a
// single-port memory of MAX_INDEX+1 words. After reset the block runs a clearing pass
// that writes one entry per cycle and accepts no item until it ends. An add item at
// position p walks the covering nodes with one read and one write each; an add at
// position zero or past the table stays in idle and gives no response. A range query
// walks the upper prefix and then the lower prefix with one pipelined memory read per
// node; a query with low above high answers zero. The memory port is the limit.
// One item is worked on at a time; the response register lets the next item enter
// while a finished sum waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module fenwick_prefix_sum_table_core #(
   parameter int unsigned MAX_INDEX = fpst_pkg::MAX_INDEX_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   fpst_req_if.sink  req_if,
   fpst_rsp_if.source rsp_if
);

   fpst_pkg::fpst_cmd_type cmd;
   fpst_pkg::fpst_sts_type sts;

   // Sequencer
   fpst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Memory, walk and accumulator
   fpst_dp #(
      .MAX_INDEX (MAX_INDEX)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .action       (req_if.action),
      .update_index (req_if.update_index),
      .delta        (req_if.delta),
      .range_low    (req_if.range_low),
      .range_high   (req_if.range_high),
      .range_sum    (rsp_if.range_sum)
   );

`ifndef NO_ASSERTIONS
   // One memory access per cycle on the single port
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.upd_read, cmd.upd_write, cmd.qry_read}))
      else $error("node memory port used twice in one cycle");

   // A node write always follows the read of the same node
   assert property (@(posedge clock) disable iff (reset)
      cmd.upd_write |-> $past(cmd.upd_read))
      else $error("node written without a preceding read");

   // No item enters during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_if.ready)
      else $error("item accepted while clearing");

   // A sum is loaded only into a free or draining response register
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_if.valid || rsp_if.ready))
      else $error("response overwritten before it was taken");
`endif

endmodule : fenwick_prefix_sum_table_core

`default_nettype wire
